FILE: hdl/pulse_interval_timecode_decoder_top_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the pulse-interval time-code decoder
// Clocked on clk, disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef PULSE_INTERVAL_TIMECODE_DECODER_TOP_DEFINES_SVH
`define PULSE_INTERVAL_TIMECODE_DECODER_TOP_DEFINES_SVH

// same-cycle implication
`define PITD_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PITD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/pitd_pkg.sv
// ---------------------------------------------------------------------------
// pitd_pkg
// Shared types and constants of the pulse-interval time-code decoder.
// ---------------------------------------------------------------------------
package pitd_pkg;

	localparam int TS_W    = 64;
	localparam int WORD_W  = 32;
	localparam int BOUND_W = 32;
	localparam int REG_IDX_W = 3;
	localparam int NUM_WIN = 3;

	localparam logic [REG_IDX_W-1:0] REG_ZERO_LOW  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_ZERO_HIGH = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_ONE_LOW   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_ONE_HIGH  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_SYNC_LOW  = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_SYNC_HIGH = 3'd5;

	localparam logic [BOUND_W-1:0] RST_ZERO_LOW  = 32'd81420;
	localparam logic [BOUND_W-1:0] RST_ZERO_HIGH = 32'd82420;
	localparam logic [BOUND_W-1:0] RST_ONE_LOW   = 32'd327180;
	localparam logic [BOUND_W-1:0] RST_ONE_HIGH  = 32'd328180;
	localparam logic [BOUND_W-1:0] RST_SYNC_LOW  = 32'd2620940;
	localparam logic [BOUND_W-1:0] RST_SYNC_HIGH = 32'd2621940;

	localparam int WIN_ZERO = 0;
	localparam int WIN_ONE  = 1;
	localparam int WIN_SYNC = 2;

	typedef enum logic [2:0] {
		ST_UNKNOWN = 3'd0,
		ST_SYNC    = 3'd1,
		ST_ZERO1   = 3'd2,
		ST_ZERO2   = 3'd3,
		ST_ONE1    = 3'd4,
		ST_ONE2    = 3'd5
	} dec_state_t;

	typedef struct packed {
		logic [REG_IDX_W-1:0] index;
		logic [BOUND_W-1:0]   value;
	} cfg_t;

	typedef struct packed {
		logic              locked;
		logic              sync_lost;
		logic              word_ready;
		logic [WORD_W-1:0] word_value;
		logic [TS_W-1:0]   word_time;
	} result_t;

	typedef struct packed {
		logic load;
		logic step;
		logic commit;
	} dp_cmd_t;

	typedef struct packed {
		logic all_done;
	} dp_status_t;

endpackage

FILE: hdl/pitd_chan_if.sv
// ---------------------------------------------------------------------------
// pitd_chan_if
// Valid/ready channel carrying one word of a given payload type.
// ---------------------------------------------------------------------------
interface pitd_chan_if #(parameter type payload_t = logic);

	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);

endinterface

FILE: hdl/pulse_interval_timecode_decoder_top.sv
// ---------------------------------------------------------------------------
// pulse_interval_timecode_decoder_top
// Decodes a pulse-interval time code from a stream of pulse timestamps.
// ---------------------------------------------------------------------------
// pulses  : sink, one 64-bit timestamp per word.
// results : source, one result word per pulse (locked, sync_lost,
//           word_ready, word_value, word_time).
// cfg     : sink, register writes (index 0..5 = zero/one/sync low/high
//           bounds); always ready, indexes beyond the list are dropped.
// A pulse enters the history on acceptance; the controller then walks the
// history one entry per cycle, checking all three windows on a shared
// 64-bit difference, and stops early once every window has decided.
// One pulse is in flight at a time; the next can be accepted the cycle after
// the result is registered, so the walk length, plus any wait at the commit,
// sets how soon the next pulse enters.
// The result register holds a finished word while the receiver stalls; the
// next pulse is accepted and walked meanwhile and waits only at its commit.
// Reset clears history, decoder state, partial word and bit count, and
// loads the default bounds.
// ---------------------------------------------------------------------------
module pulse_interval_timecode_decoder_top import pitd_pkg::*; #(
	parameter int HISTORY_DEPTH = 10,
	parameter int WORD_BITS = 32
) (
	input logic         clk,
	input logic         arst_n,
	pitd_chan_if.sink   pulses,
	pitd_chan_if.source results,
	pitd_chan_if.sink   cfg
);

	localparam int IDX_W = $clog2(HISTORY_DEPTH);

	dp_cmd_t          cmd;
	dp_status_t       status;
	logic [IDX_W-1:0] idx;
	result_t          result;
	cfg_t             cfg_word;
	logic [TS_W-1:0]  pulse_time;

	assign cfg.ready    = 1'b1;
	assign cfg_word     = cfg.data;
	assign pulse_time   = pulses.data;
	assign results.data = result;

	pitd_ctrl #(
		.HISTORY_DEPTH(HISTORY_DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pulses.valid),
		.in_ready (pulses.ready),
		.out_valid(results.valid),
		.out_ready(results.ready),
		.status   (status),
		.cmd      (cmd),
		.idx      (idx)
	);

	pitd_dp #(
		.HISTORY_DEPTH(HISTORY_DEPTH),
		.WORD_BITS    (WORD_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.idx       (idx),
		.pulse_time(pulse_time),
		.cfg_we    (cfg.valid),
		.cfg_word  (cfg_word),
		.status    (status),
		.result    (result)
	);

endmodule

FILE: hdl/pitd_dp.sv
// ---------------------------------------------------------------------------
// pitd_dp
// Datapath: pulse history, window walk, decoder state and result register.
// ---------------------------------------------------------------------------
module pitd_dp import pitd_pkg::*; #(
	parameter int HISTORY_DEPTH = 10,
	parameter int WORD_BITS = 32,
	localparam int IDX_W = $clog2(HISTORY_DEPTH),
	localparam int CNT_W = $clog2(WORD_BITS)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  dp_cmd_t          cmd,
	input  logic [IDX_W-1:0] idx,
	input  logic [TS_W-1:0]  pulse_time,
	input  logic             cfg_we,
	input  cfg_t             cfg_word,
	output dp_status_t       status,
	output result_t          result
);

	logic [BOUND_W-1:0] zero_low_q, zero_high_q, one_low_q, one_high_q;
	logic [BOUND_W-1:0] sync_low_q, sync_high_q;
	logic [BOUND_W-1:0] win_lo [NUM_WIN];
	logic [BOUND_W-1:0] win_hi [NUM_WIN];

	logic [TS_W-1:0] hist_q [HISTORY_DEPTH];
	logic [TS_W-1:0] diff;
	logic [NUM_WIN-1:0] done_q, hit_q, done_d, hit_d;

	dec_state_t state_q, state_d;
	logic [WORD_BITS-1:0] part_q, part_d, part_bit;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [WORD_W-1:0] last_word_q, last_word_d;
	logic [TS_W-1:0] last_time_q, last_time_d;
	logic lost, ready, add, bit_val;
	logic h0, h1, hs;
	result_t result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_low_q  <= RST_ZERO_LOW;
			zero_high_q <= RST_ZERO_HIGH;
			one_low_q   <= RST_ONE_LOW;
			one_high_q  <= RST_ONE_HIGH;
			sync_low_q  <= RST_SYNC_LOW;
			sync_high_q <= RST_SYNC_HIGH;
		end else if (cfg_we) begin
			case (cfg_word.index)
				REG_ZERO_LOW:  zero_low_q  <= cfg_word.value;
				REG_ZERO_HIGH: zero_high_q <= cfg_word.value;
				REG_ONE_LOW:   one_low_q   <= cfg_word.value;
				REG_ONE_HIGH:  one_high_q  <= cfg_word.value;
				REG_SYNC_LOW:  sync_low_q  <= cfg_word.value;
				REG_SYNC_HIGH: sync_high_q <= cfg_word.value;
				default: ;
			endcase
		end
	end

	assign win_lo[WIN_ZERO] = zero_low_q;
	assign win_hi[WIN_ZERO] = zero_high_q;
	assign win_lo[WIN_ONE]  = one_low_q;
	assign win_hi[WIN_ONE]  = one_high_q;
	assign win_lo[WIN_SYNC] = sync_low_q;
	assign win_hi[WIN_SYNC] = sync_high_q;

	assign diff = hist_q[0] - hist_q[idx];

	always_comb begin
		done_d = done_q;
		hit_d  = hit_q;
		for (int w = 0; w < NUM_WIN; w++) begin
			if (!done_q[w]) begin
				if (diff[TS_W-1:BOUND_W] != '0 || diff[BOUND_W-1:0] > win_hi[w]) begin
					done_d[w] = 1'b1;
					hit_d[w]  = 1'b0;
				end else if (diff[BOUND_W-1:0] > win_lo[w]) begin
					done_d[w] = 1'b1;
					hit_d[w]  = 1'b1;
				end
			end
		end
	end

	assign status.all_done = &done_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HISTORY_DEPTH; i++) hist_q[i] <= '0;
			done_q <= '0;
			hit_q  <= '0;
		end else if (cmd.load) begin
			hist_q[0] <= pulse_time;
			for (int i = 1; i < HISTORY_DEPTH; i++) hist_q[i] <= hist_q[i-1];
			done_q <= '0;
			hit_q  <= '0;
		end else if (cmd.step) begin
			done_q <= done_d;
			hit_q  <= hit_d;
		end
	end

	assign h0 = hit_q[WIN_ZERO];
	assign h1 = hit_q[WIN_ONE];
	assign hs = hit_q[WIN_SYNC];

	always_comb begin
		state_d     = state_q;
		part_d      = part_q;
		cnt_d       = cnt_q;
		last_word_d = last_word_q;
		last_time_d = last_time_q;
		lost        = 1'b0;
		ready       = 1'b0;
		add         = 1'b0;
		bit_val     = 1'b0;
		part_bit    = part_q;
		case (state_q)
			ST_UNKNOWN: begin
				if (hs) state_d = ST_SYNC;
			end
			ST_SYNC: begin
				if (h0) state_d = ST_ZERO1;
				else if (h1) state_d = ST_ONE1;
				else if (hs) begin
					part_d = '0;
					cnt_d  = '0;
				end else lost = 1'b1;
			end
			ST_ZERO1: begin
				if (h0) begin
					add     = 1'b1;
					state_d = ST_ZERO2;
				end else lost = 1'b1;
			end
			ST_ONE1: begin
				if (h1) begin
					add     = 1'b1;
					bit_val = 1'b1;
					state_d = ST_ONE2;
				end else lost = 1'b1;
			end
			ST_ZERO2, ST_ONE2: begin
				if (hs) state_d = ST_SYNC;
				else lost = 1'b1;
			end
			default: lost = 1'b1;
		endcase
		if (add) begin
			if (bit_val) part_bit[cnt_q] = 1'b1;
			if (cnt_q == CNT_W'(WORD_BITS - 1)) begin
				last_word_d = WORD_W'(part_bit);
				last_time_d = hist_q[0];
				part_d      = '0;
				cnt_d       = '0;
				ready       = 1'b1;
			end else begin
				part_d = part_bit;
				cnt_d  = cnt_q + CNT_W'(1);
			end
		end
		if (lost) begin
			state_d = ST_UNKNOWN;
			part_d  = '0;
			cnt_d   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_UNKNOWN;
			part_q      <= '0;
			cnt_q       <= '0;
			last_word_q <= '0;
			last_time_q <= '0;
		end else if (cmd.commit) begin
			state_q     <= state_d;
			part_q      <= part_d;
			cnt_q       <= cnt_d;
			last_word_q <= last_word_d;
			last_time_q <= last_time_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			result_q.locked     <= (state_d != ST_UNKNOWN);
			result_q.sync_lost  <= lost;
			result_q.word_ready <= ready;
			result_q.word_value <= last_word_d;
			result_q.word_time  <= last_time_d;
		end
	end

	assign result = result_q;

endmodule

FILE: hdl/pitd_ctrl.sv
// ---------------------------------------------------------------------------
// pitd_ctrl
// Controller: input handshake, history walk sequencing, output valid.
// ---------------------------------------------------------------------------
`include "pulse_interval_timecode_decoder_top_defines.svh"

module pitd_ctrl import pitd_pkg::*; #(
	parameter int HISTORY_DEPTH = 10,
	localparam int IDX_W = $clog2(HISTORY_DEPTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  dp_status_t       status,
	output dp_cmd_t          cmd,
	output logic [IDX_W-1:0] idx
);

	localparam logic [IDX_W-1:0] LAST = IDX_W'(HISTORY_DEPTH - 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_UPDATE
	} ctrl_state_t;

	ctrl_state_t state_q;
	logic [IDX_W-1:0] idx_q;
	logic out_valid_q;

	assign in_ready   = (state_q == S_IDLE);
	assign cmd.load   = in_valid && in_ready;
	assign cmd.step   = (state_q == S_WALK);
	assign cmd.commit = (state_q == S_UPDATE) && (!out_valid_q || out_ready);
	assign idx        = idx_q;
	assign out_valid  = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_WALK;
						idx_q   <= IDX_W'(1);
					end
				end
				S_WALK: begin
					if (idx_q == LAST || status.all_done) state_q <= S_UPDATE;
					else idx_q <= idx_q + IDX_W'(1);
				end
				S_UPDATE: begin
					if (cmd.commit) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`PITD_ASSERT_NEXT(a_accept_starts_walk, in_valid && in_ready, cmd.step && idx_q == IDX_W'(1), "walk did not start after accept")
	`PITD_ASSERT_NEXT(a_commit_sets_valid, cmd.commit, out_valid_q && in_ready, "commit did not raise output valid")
	`PITD_ASSERT_IMPL(a_walk_index_range, cmd.step, idx_q != '0 && idx_q <= LAST, "walk index out of range")

endmodule

FILE: tb/pulse_interval_timecode_decoder_top_tb.sv
// ---------------------------------------------------------------------------
// pulse_interval_timecode_decoder_top_tb
// Drives pulse timestamps into the decoder and checks every result word
// against a cycle-free model of the history windows and the lock/bit state
// machine. Runs a directed opening, then framed pulse trains with noise and
// broken frames under several window settings, with random gaps and stalls
// on both channels and one long receiver hold-off.
// ---------------------------------------------------------------------------
module pulse_interval_timecode_decoder_top_tb;
	import pitd_pkg::*;

	localparam int HISTORY_DEPTH   = 10;
	localparam int WORD_BITS       = 32;
	localparam int CLK_HALF        = 4;
	localparam int DRAIN_CYCLES    = HISTORY_DEPTH + 6;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int CYCLE_LIMIT     = 1000000;
	localparam int PRINT_LIMIT     = 50;

	localparam logic [REG_IDX_W-1:0] REG_SPARE_A = REG_SYNC_HIGH + 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_SPARE_B = REG_SYNC_HIGH + 3'd2;

	class timecode_scoreboard;
		logic [BOUND_W-1:0] win_low [NUM_WIN];
		logic [BOUND_W-1:0] win_high [NUM_WIN];
		logic [TS_W-1:0]    history [HISTORY_DEPTH];
		dec_state_t         state;
		logic [WORD_W-1:0]  partial;
		int                 nbits;
		logic [WORD_W-1:0]  word;
		logic [TS_W-1:0]    word_ts;
		result_t            pending_results [$];
		int                 errors;

		function new();
			win_low[WIN_ZERO]  = RST_ZERO_LOW;
			win_high[WIN_ZERO] = RST_ZERO_HIGH;
			win_low[WIN_ONE]   = RST_ONE_LOW;
			win_high[WIN_ONE]  = RST_ONE_HIGH;
			win_low[WIN_SYNC]  = RST_SYNC_LOW;
			win_high[WIN_SYNC] = RST_SYNC_HIGH;
			foreach (history[i]) history[i] = '0;
			state   = ST_UNKNOWN;
			partial = '0;
			nbits   = 0;
			word    = '0;
			word_ts = '0;
			errors  = 0;
		endfunction

		function void write_reg(logic [REG_IDX_W-1:0] idx, logic [BOUND_W-1:0] value);
			case (idx)
				REG_ZERO_LOW:  win_low[WIN_ZERO]  = value;
				REG_ZERO_HIGH: win_high[WIN_ZERO] = value;
				REG_ONE_LOW:   win_low[WIN_ONE]   = value;
				REG_ONE_HIGH:  win_high[WIN_ONE]  = value;
				REG_SYNC_LOW:  win_low[WIN_SYNC]  = value;
				REG_SYNC_HIGH: win_high[WIN_SYNC] = value;
				default: ;
			endcase
		endfunction

		// first decisive difference, newest back to oldest, modulo 2^64
		function bit window_hit(int w);
			logic [TS_W-1:0] d;
			for (int i = 1; i < HISTORY_DEPTH; i++) begin
				d = history[0] - history[i];
				if (d > {32'd0, win_high[w]}) return 1'b0;
				if (d > {32'd0, win_low[w]}) return 1'b1;
			end
			return 1'b0;
		endfunction

		function void note_pulse(logic [TS_W-1:0] ts);
			result_t res;
			bit      hit_zero;
			bit      hit_one;
			bit      hit_sync;
			bit      lost;
			bit      done;
			bit      hit_bit;
			for (int i = HISTORY_DEPTH - 1; i > 0; i--) history[i] = history[i-1];
			history[0] = ts;
			hit_zero = window_hit(WIN_ZERO);
			hit_one  = window_hit(WIN_ONE);
			hit_sync = window_hit(WIN_SYNC);
			lost = 1'b0;
			done = 1'b0;
			case (state)
				ST_UNKNOWN: begin
					if (hit_sync) state = ST_SYNC;
				end
				ST_SYNC: begin
					if (hit_zero) state = ST_ZERO1;
					else if (hit_one) state = ST_ONE1;
					else if (hit_sync) begin
						partial = '0;
						nbits   = 0;
					end else lost = 1'b1;
				end
				ST_ZERO1, ST_ONE1: begin
					hit_bit = (state == ST_ZERO1) ? hit_zero : hit_one;
					if (hit_bit) begin
						partial[nbits] = (state == ST_ONE1);
						nbits++;
						if (nbits >= WORD_BITS) begin
							word    = partial;
							word_ts = ts;
							partial = '0;
							nbits   = 0;
							done    = 1'b1;
						end
						if (state == ST_ZERO1) state = ST_ZERO2;
						else state = ST_ONE2;
					end else lost = 1'b1;
				end
				ST_ZERO2, ST_ONE2: begin
					if (hit_sync) state = ST_SYNC;
					else lost = 1'b1;
				end
				default: lost = 1'b1;
			endcase
			if (lost) begin
				state   = ST_UNKNOWN;
				partial = '0;
				nbits   = 0;
			end
			res.locked     = (state != ST_UNKNOWN);
			res.sync_lost  = lost;
			res.word_ready = done;
			res.word_value = word;
			res.word_time  = word_ts;
			pending_results.push_back(res);
		endfunction

		function void compare_field(string name, logic [TS_W-1:0] want, logic [TS_W-1:0] got);
			if (want !== got) begin
				if (errors < PRINT_LIMIT)
					$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending_results.size() == 0) begin
				if (errors < PRINT_LIMIT)
					$display("%0t: result word with no pulse pending, expected none, actual %h",
						$time, got);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			compare_field("locked", TS_W'(want.locked), TS_W'(got.locked));
			compare_field("sync_lost", TS_W'(want.sync_lost), TS_W'(got.sync_lost));
			compare_field("word_ready", TS_W'(want.word_ready), TS_W'(got.word_ready));
			compare_field("word_value", TS_W'(want.word_value), TS_W'(got.word_value));
			compare_field("word_time", want.word_time, got.word_time);
		endfunction
	endclass

	logic clk;
	logic arst_n;

	pitd_chan_if #(.payload_t(logic [TS_W-1:0])) pulse_ch ();
	pitd_chan_if #(.payload_t(result_t))         result_ch ();
	pitd_chan_if #(.payload_t(cfg_t))            cfg_ch ();

	timecode_scoreboard sb;
	logic [TS_W-1:0]    interval_plan [$];
	logic [TS_W-1:0]    next_ts;
	bit                 steady;
	bit                 held_off;
	int                 results_seen;
	int                 cycles;

	pulse_interval_timecode_decoder_top #(
		.HISTORY_DEPTH(HISTORY_DEPTH),
		.WORD_BITS(WORD_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.pulses(pulse_ch),
		.results(result_ch),
		.cfg(cfg_ch)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (pulse_ch.valid && pulse_ch.ready) sb.note_pulse(pulse_ch.data);
			if (result_ch.valid && result_ch.ready) begin
				sb.check_result(result_ch.data);
				results_seen++;
			end
			if (cfg_ch.valid && cfg_ch.ready) sb.write_reg(cfg_ch.data.index, cfg_ch.data.value);
		end
	end

	function automatic int idle_gap();
		int r;
		if (steady) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [TS_W-1:0] noise_interval();
		case ($urandom_range(0, 3))
			0: return {$urandom, $urandom};
			1: return {32'd0, $urandom_range(0, 2000)};
			2: return {32'd0, $urandom};
			default: return '0;
		endcase
	endfunction

	function automatic logic [TS_W-1:0] pick_interval(int w);
		logic [TS_W-1:0] lo;
		logic [TS_W-1:0] hi;
		lo = {32'd0, sb.win_low[w]};
		hi = {32'd0, sb.win_high[w]};
		if (hi <= lo) return noise_interval();
		case ($urandom_range(0, 9))
			0: return hi;
			1: return lo + 1;
			default: return lo + 1 + ({32'd0, $urandom} % (hi - lo));
		endcase
	endfunction

	function automatic void plan_push(logic [TS_W-1:0] iv);
		if ($urandom_range(0, 99) == 0) interval_plan.push_back(noise_interval());
		else interval_plan.push_back(iv);
	endfunction

	// one frame (sync lead-in, then zero/one bits as two marks and a sync each), a noise burst or a broken frame
	function automatic void plan_frame();
		int r;
		int nb;
		int w;
		r = $urandom_range(0, 99);
		if (r < 80) begin
			plan_push(pick_interval(WIN_SYNC));
			if ($urandom_range(0, 3) == 0) plan_push(pick_interval(WIN_SYNC));
			nb = ($urandom_range(0, 9) < 7) ? WORD_BITS : $urandom_range(1, WORD_BITS + 8);
			for (int b = 0; b < nb; b++) begin
				w = $urandom_range(0, 1) ? WIN_ONE : WIN_ZERO;
				plan_push(pick_interval(w));
				plan_push(pick_interval(w));
				plan_push(pick_interval(WIN_SYNC));
			end
		end else if (r < 92) begin
			nb = $urandom_range(1, 5);
			for (int k = 0; k < nb; k++) interval_plan.push_back(noise_interval());
		end else begin
			interval_plan.push_back(pick_interval(WIN_SYNC));
			w = $urandom_range(0, 1) ? WIN_ONE : WIN_ZERO;
			interval_plan.push_back(pick_interval(w));
			interval_plan.push_back(pick_interval(w == WIN_ONE ? WIN_ZERO : WIN_ONE));
		end
	endfunction

	task automatic send_pulse(input logic [TS_W-1:0] ts, input int gap);
		repeat (gap) begin
			@(negedge clk);
			pulse_ch.valid <= 1'b0;
		end
		@(negedge clk);
		pulse_ch.valid <= 1'b1;
		pulse_ch.data  <= ts;
		do @(posedge clk); while (!pulse_ch.ready);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [BOUND_W-1:0] value);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= {idx, value};
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic set_windows(input logic [BOUND_W-1:0] zl, zh, ol, oh, sl, sh);
		write_reg(REG_ZERO_LOW, zl);
		write_reg(REG_ZERO_HIGH, zh);
		write_reg(REG_ONE_LOW, ol);
		write_reg(REG_ONE_HIGH, oh);
		write_reg(REG_SYNC_LOW, sl);
		write_reg(REG_SYNC_HIGH, sh);
	endtask

	task automatic drain();
		@(negedge clk);
		pulse_ch.valid <= 1'b0;
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic run_stream(input int count);
		for (int k = 0; k < count; k++) begin
			if (k % 64 == 0) steady = ($urandom_range(0, 3) == 0);
			if (interval_plan.size() == 0) plan_frame();
			next_ts = next_ts + interval_plan.pop_front();
			send_pulse(next_ts, idle_gap());
		end
	endtask

	task automatic run_directed();
		next_ts = '0;
		send_pulse(next_ts, idle_gap());
		next_ts = {32'd0, RST_SYNC_HIGH};
		send_pulse(next_ts, idle_gap());
		next_ts = next_ts + RST_SYNC_HIGH;
		send_pulse(next_ts, idle_gap());
		next_ts = next_ts + RST_ZERO_HIGH;
		send_pulse(next_ts, idle_gap());
		next_ts = next_ts + RST_ZERO_LOW + 1;
		send_pulse(next_ts, idle_gap());
		next_ts = next_ts + RST_SYNC_LOW + 1;
		send_pulse(next_ts, idle_gap());
		next_ts = next_ts + RST_ONE_LOW + 1;
		send_pulse(next_ts, idle_gap());
		next_ts = next_ts + RST_ONE_HIGH;
		send_pulse(next_ts, idle_gap());
		next_ts = next_ts + RST_SYNC_LOW;
		send_pulse(next_ts, idle_gap());
		next_ts = '1;
		send_pulse(next_ts, idle_gap());
		next_ts = next_ts + RST_SYNC_HIGH;
		send_pulse(next_ts, idle_gap());
		next_ts = next_ts - 100;
		send_pulse(next_ts, idle_gap());
		next_ts = next_ts + RST_ZERO_HIGH + 1;
		send_pulse(next_ts, idle_gap());
		next_ts = next_ts + RST_SYNC_HIGH;
		send_pulse(next_ts, idle_gap());
	endtask

	initial begin
		int stall;
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held_off && results_seen >= 150) begin
				held_off = 1'b1;
				result_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
			end else begin
				stall = idle_gap();
				result_ch.ready <= (stall == 0);
				if (stall > 1) repeat (stall - 1) @(negedge clk);
			end
		end
	end

	initial begin
		sb = new();
		steady         = 1'b0;
		held_off       = 1'b0;
		results_seen   = 0;
		cycles         = 0;
		arst_n         = 1'b0;
		pulse_ch.valid = 1'b0;
		pulse_ch.data  = '0;
		cfg_ch.valid   = 1'b0;
		cfg_ch.data    = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		run_directed();
		run_stream(800);

		drain();
		set_windows(32'd900, 32'd1100, 32'd3000, 32'd3300, 32'd20000, 32'd20600);
		write_reg(REG_SPARE_A, {$urandom});
		write_reg(REG_SPARE_B, 32'hFFFF_FFFF);
		interval_plan.delete();
		next_ts = {$urandom, $urandom};
		run_stream(500);

		drain();
		set_windows(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
		interval_plan.delete();
		next_ts = {$urandom, $urandom};
		run_stream(250);

		drain();
		set_windows(RST_ZERO_LOW, RST_ZERO_HIGH, RST_ONE_LOW, RST_ONE_HIGH,
			RST_SYNC_LOW, RST_SYNC_HIGH);
		interval_plan.delete();
		next_ts = {$urandom, $urandom};
		run_stream(400);

		drain();
		if (sb.errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
